FILE: rtl/pse_pkg.sv
// pse_pkg: shared types, constants and helpers for the postfix stack evaluator
// used by pse_ram users, pse_alu and postfix_stack_evaluator; no dependencies
package pse_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DATA_W      = 8;

  // ascii codes of the accepted characters
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  // status codes, first one seen in an expression sticks
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIV0  = 3'd3,
    ST_ZNEG  = 3'd4,
    ST_BAD   = 3'd5
  } status_t;

  // operations of the shared arithmetic unit
  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } alu_op_t;

  // arithmetic unit sequencer
  typedef enum logic [2:0] {
    AS_IDLE,
    AS_POW,
    AS_DIV,
    AS_SIGN,
    AS_DONE
  } alu_state_t;

  // top level sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_POP_WAIT,
    S_EXEC,
    S_ALU_WAIT,
    S_FINISH,
    S_EMIT
  } seq_state_t;

  // destination of a stack pop
  typedef enum logic [1:0] {
    POP_R,
    POP_L,
    POP_ANS
  } pop_tgt_t;

  // request to the arithmetic unit
  typedef struct packed {
    logic               start;
    alu_op_t            op;
    logic signed [7:0]  lhs;
    logic signed [7:0]  rhs;
  } alu_req_t;

  // response from the arithmetic unit
  typedef struct packed {
    logic               done;
    logic [7:0]         value;
    logic               div0;
    logic               zneg;
  } alu_rsp_t;

  // keep the first error only
  function automatic status_t flag_st(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

FILE: rtl/postfix_stack_evaluator.sv
// postfix_stack_evaluator: top level, token sequencer, operand stack ram and
// output register; depends on pse_pkg, pse_ram and pse_alu
//
// Usage: one ascii character per word on the input channel (token, last_token).
// Digits push their value on an 8-bit signed stack, + - * / $ pop right then
// left operand and push the wrapped result. On a word with last_token set the
// character is processed, the stack top is popped and one output word
// (answer, status) is produced; stack and sticky status are then cleared.
// Flow: a word is taken only while the sequencer is idle. Operators wait for
// the shared arithmetic unit; / runs a bit-serial divider and $ with a positive
// exponent repeats the multiply on the one multiplier. The stack lives in a ram
// with a registered read port, so a pop of a non-empty stack reads in S_POP and
// takes the data in S_POP_WAIT; the answer is written in S_EMIT, which waits
// while the previous answer is still held. The output register holds a word until
// it is taken; the input side keeps working while it waits, and the block
// stalls only when a new answer must be written and the old one is still held.
// Reset: synchronous, clears stack count, status and output valid; stack ram
// contents are not cleared, entries are only read after being written.
module postfix_stack_evaluator (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        token,
  input  logic              last_token,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] answer,
  output logic [2:0]        status
);
  import pse_pkg::*;

  seq_state_t state, state_next;
  pop_tgt_t   pop_tgt;

  logic [7:0]       tok;
  logic             last;
  alu_op_t          op;
  logic [7:0]       opr_r;
  logic [7:0]       opr_l;
  logic [7:0]       ans_val;
  logic [CNT_W-1:0] count;
  status_t          sticky;

  logic             in_go;
  logic             emit_go;
  logic             is_digit;
  logic             is_op;
  alu_op_t          dec_op;
  logic [7:0]       digit_val;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] cnt_dec;
  logic [7:0]       pop_data;
  logic             pop_write;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // token decode
  always_comb begin
    is_digit  = (tok >= CH_ZERO) && (tok <= CH_NINE);
    digit_val = tok - CH_ZERO;
    is_op     = 1'b1;
    dec_op    = OP_ADD;
    case (tok)
      CH_PLUS:   dec_op = OP_ADD;
      CH_MINUS:  dec_op = OP_SUB;
      CH_STAR:   dec_op = OP_MUL;
      CH_SLASH:  dec_op = OP_DIV;
      CH_DOLLAR: dec_op = OP_POW;
      default:   is_op  = 1'b0;
    endcase
  end

  // stack pointer helpers
  always_comb begin
    full     = (count >= CNT_W'(STACK_DEPTH));
    empty    = (count == '0);
    cnt_dec  = count - CNT_W'(1);
    pop_data = (state == S_POP_WAIT) ? ram_rdata : 8'd0;
    pop_write = (state == S_POP_WAIT) || (state == S_POP && empty);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: state_next = (!is_digit && is_op) ? S_POP : S_FINISH;
      S_POP,
      S_POP_WAIT: begin
        if (state == S_POP && !empty) begin
          state_next = S_POP_WAIT;
        end else begin
          unique case (pop_tgt)
            POP_R:   state_next = S_POP;
            POP_L:   state_next = S_EXEC;
            POP_ANS: state_next = S_EMIT;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_EXEC:     state_next = S_ALU_WAIT;
      S_ALU_WAIT: if (alu_rsp.done) state_next = S_FINISH;
      S_FINISH:   state_next = last ? S_POP : S_IDLE;
      S_EMIT:     if (emit_go) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state != S_IDLE);
    in_go     = in_valid && (state == S_IDLE);
    emit_go   = (state == S_EMIT) && (!out_valid || !out_stall);
    ram_we    = !full && (((state == S_DECODE) && is_digit) ||
                          ((state == S_ALU_WAIT) && alu_rsp.done));
    ram_waddr = count[ADDR_W-1:0];
    ram_wdata = (state == S_DECODE) ? digit_val : alu_rsp.value;
    ram_re    = (state == S_POP) && !empty;
    ram_raddr = cnt_dec[ADDR_W-1:0];
    alu_req.start = (state == S_EXEC);
    alu_req.op    = op;
    alu_req.lhs   = opr_l;
    alu_req.rhs   = opr_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (in_go) begin
      tok  <= token;
      last <= last_token;
    end
    if (state == S_DECODE) begin
      op <= dec_op;
    end
  end

  // pop destination tracking
  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      pop_tgt <= POP_R;
    end else if (state == S_FINISH) begin
      pop_tgt <= POP_ANS;
    end else if (pop_write && pop_tgt == POP_R) begin
      pop_tgt <= POP_L;
    end
  end

  // popped operands
  always_ff @(posedge clk) begin
    if (pop_write) begin
      case (pop_tgt)
        POP_R:   opr_r   <= pop_data;
        POP_L:   opr_l   <= pop_data;
        default: ans_val <= pop_data;
      endcase
    end
  end

  // stack count and sticky status
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      sticky <= ST_OK;
    end else begin
      case (state)
        S_DECODE: begin
          if (is_digit) begin
            if (full) sticky <= flag_st(sticky, ST_OVER);
            else      count  <= count + CNT_W'(1);
          end else if (!is_op) begin
            sticky <= flag_st(sticky, ST_BAD);
          end
        end
        S_POP: begin
          if (empty) sticky <= flag_st(sticky, ST_UNDER);
          else       count  <= cnt_dec;
        end
        S_ALU_WAIT: begin
          if (alu_rsp.done) begin
            if (alu_rsp.div0) begin
              sticky <= flag_st(sticky, ST_DIV0);
            end else if (alu_rsp.zneg) begin
              sticky <= flag_st(sticky, ST_ZNEG);
            end else if (full) begin
              sticky <= flag_st(sticky, ST_OVER);
            end
            if (!full) count <= count + CNT_W'(1);
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            count  <= '0;
            sticky <= ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      answer <= ans_val;
      status <= sticky;
    end
  end

  // operand stack
  pse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared arithmetic unit
  pse_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // stack count stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // no write past the top of the stack
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> count < CNT_W'(STACK_DEPTH))
    else $error("stack write while full");

  // an emitted answer leaves an empty stack and clean status
  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> count == '0 && sticky == ST_OK && out_valid)
    else $error("state not cleared after answer");

  // read data is only consumed in the cycle after a stack read
  a_pop_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP_WAIT) |-> $past(ram_re))
    else $error("pop without stack read");

endmodule

FILE: rtl/pse_ram.sv
// pse_ram: generic single write port, single read port ram with registered read
// no package dependencies
module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pse_alu.sv
// pse_alu: shared 8-bit arithmetic unit, one multiplier reused for power steps
// and a bit-serial restoring divider; depends on pse_pkg
module pse_alu (
  input  logic              clk,
  input  logic              rst,
  input  pse_pkg::alu_req_t req,
  output pse_pkg::alu_rsp_t rsp
);
  import pse_pkg::*;

  alu_state_t state, state_next;

  logic [7:0] acc;
  logic [7:0] base;
  logic [6:0] cnt;
  logic [7:0] rem;
  logic [7:0] dvd;
  logic [7:0] dvs;
  logic       neg;
  logic       div0;
  logic       zneg;

  logic [7:0]  mul_a;
  logic [7:0]  mul_b;
  logic [15:0] mul_p;
  logic [8:0]  rem_sh;
  logic        rem_ge;
  logic [8:0]  rem_sub;
  logic [7:0]  abs_l;
  logic [7:0]  abs_r;

  // shared multiplier: operands during a power loop, else the request
  always_comb begin
    mul_a = (state == AS_POW) ? acc  : req.lhs;
    mul_b = (state == AS_POW) ? base : req.rhs;
    mul_p = mul_a * mul_b;
  end

  // one restoring division step and the operand magnitudes
  always_comb begin
    rem_sh  = {rem, dvd[7]};
    rem_ge  = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
    abs_l   = req.lhs[7] ? 8'(-req.lhs) : req.lhs;
    abs_r   = req.rhs[7] ? 8'(-req.rhs) : req.rhs;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      AS_IDLE: begin
        if (req.start) begin
          if (req.op == OP_DIV && req.rhs != 8'sd0) begin
            state_next = AS_DIV;
          end else if (req.op == OP_POW && !req.rhs[7] && req.rhs != 8'sd0) begin
            state_next = AS_POW;
          end else begin
            state_next = AS_DONE;
          end
        end
      end
      AS_POW:  if (cnt == 7'd1) state_next = AS_DONE;
      AS_DIV:  if (cnt == 7'd1) state_next = AS_SIGN;
      AS_SIGN: state_next = AS_DONE;
      AS_DONE: state_next = AS_IDLE;
      default: state_next = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      AS_IDLE: begin
        if (req.start) begin
          div0 <= 1'b0;
          zneg <= 1'b0;
          base <= req.lhs;
          case (req.op)
            OP_ADD: acc <= 8'(req.lhs + req.rhs);
            OP_SUB: acc <= 8'(req.lhs - req.rhs);
            OP_MUL: acc <= mul_p[7:0];
            OP_DIV: begin
              acc  <= 8'd0;
              div0 <= (req.rhs == 8'sd0);
              dvd  <= abs_l;
              dvs  <= abs_r;
              rem  <= 8'd0;
              cnt  <= 7'd8;
              neg  <= req.lhs[7] ^ req.rhs[7];
            end
            OP_POW: begin
              cnt <= req.rhs[6:0];
              if (req.rhs[7]) begin
                // negative exponent: only unit magnitude bases survive
                if (req.lhs == 8'sd1) begin
                  acc <= 8'd1;
                end else if (req.lhs == -8'sd1) begin
                  acc <= req.rhs[0] ? 8'hFF : 8'd1;
                end else begin
                  acc <= 8'd0;
                end
                zneg <= (req.lhs == 8'sd0);
              end else begin
                acc <= 8'd1;
              end
            end
            default: acc <= 8'd0;
          endcase
        end
      end
      AS_POW: begin
        acc <= mul_p[7:0];
        cnt <= cnt - 7'd1;
      end
      AS_DIV: begin
        rem <= rem_ge ? rem_sub[7:0] : rem_sh[7:0];
        dvd <= {dvd[6:0], rem_ge};
        cnt <= cnt - 7'd1;
      end
      AS_SIGN: acc <= neg ? 8'(-dvd) : dvd;
      default: ;
    endcase
  end

  // response
  always_comb begin
    rsp.done  = (state == AS_DONE);
    rsp.value = acc;
    rsp.div0  = div0;
    rsp.zneg  = zneg;
  end

  // a request only arrives while idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == AS_IDLE)
    else $error("alu start while busy");

  // the sign fix is only entered from the last division step
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == AS_SIGN) |-> $past(state) == AS_DIV && $past(cnt) == 7'd1)
    else $error("divider step count wrong");

endmodule
